### sv/wdt_pkg.sv
// Shared types, codes and defaults for the wall dwell-time tracker.
package wdt_pkg;

  localparam int unsigned NumParticlesDef = 4096;
  localparam int unsigned NumBinsDef      = 256;

  localparam int unsigned HeightW  = 23;
  localparam int unsigned ZW       = 24;
  localparam int unsigned FrameW   = 24;
  localparam int unsigned MaxResW  = 9;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 23;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_HEIGHT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WALL_CUTOFF    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RESIDENCE  = 2'd2;

  localparam logic [HeightW-1:0] ChannelHeightRst = 23'd25600;
  localparam logic [HeightW-1:0] WallCutoffRst    = 23'd3840;
  localparam logic [MaxResW-1:0] MaxResidenceRst  = 9'd200;

  // request and event codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [11:0]        particle_index;
    logic [FrameW-1:0]  frame;
    logic signed [ZW-1:0] height_z;
    logic               is_gas;
    logic [7:0]         bin_select;
  } req_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [FrameW-1:0] residence_frames;
    logic              left_at_top;
    logic              was_binned;
    logic [CountW-1:0] bin_count;
    logic [FrameW-1:0] longest_residence;
    logic [CountW-1:0] started_total;
    logic [CountW-1:0] ended_top_total;
    logic [CountW-1:0] ended_bottom_total;
  } rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clear;   // zero one table row per cycle
    logic accept;  // input beat taken, particle row read issued
    logic calc;    // particle row in hand, histogram read issued
    logic done;    // histogram word in hand, commit and load output
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } status_t;

endpackage

### sv/wall_dwell_time_tracker_top.sv
// Wall dwell-time tracker: per-particle wall collision timing and residence histogram.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat is a particle sample or
// a histogram bin read. Output channel (out_valid_o / out_stall_i / out_data_o): exactly
// one result beat per input beat, in order. Config channel (cfg_valid_i / cfg_ready_o):
// always ready; write only while the block is idle.
// Each beat takes three steps: particle table read, histogram read, commit. The next
// beat enters on the commit step, so a new beat is not taken during the histogram
// read step: the particle table read must follow the previous row write-back.
// out_valid_o comes from the output register, loaded on the commit step.
// After reset the block zeroes the particle table and histogram one row per cycle,
// max(NUM_PARTICLES, NUM_BINS) rows in all, holding in_stall_o high; config writes are
// taken during that time. A stalled output holds its beat; the block then holds the
// commit step and stalls further input beats.
module wall_dwell_time_tracker_top import wdt_pkg::*; #(
  parameter int unsigned NUM_PARTICLES = NumParticlesDef,
  parameter int unsigned NUM_BINS      = NumBinsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  req_t                in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsp_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  wdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wdt_dpath #(
    .NUM_PARTICLES (NUM_PARTICLES),
    .NUM_BINS      (NUM_BINS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/wdt_ctrl.sv
// Sequencer for the dwell-time tracker: clearing pass and per-beat steps.
module wdt_ctrl import wdt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   go;
  logic   can_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_CALC;
      end
      S_CALC: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!status_i.out_busy) state_d = in_valid_i ? S_CALC : S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // next beat may enter on the commit cycle of the current one
  always_comb begin
    go         = (state_q == S_DONE) && !status_i.out_busy;
    can_accept = (state_q == S_IDLE) || go;
    in_stall_o = !can_accept;
    cmd_o.clear  = (state_q == S_CLEAR);
    cmd_o.calc   = (state_q == S_CALC);
    cmd_o.done   = go;
    cmd_o.accept = can_accept && in_valid_i;
  end

`ifndef SYNTHESIS
  a_accept_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> (state_q == S_IDLE) || (state_q == S_DONE))
    else $error("beat accepted outside idle or commit");
  a_calc_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CALC |=> state_q == S_DONE)
    else $error("calc step not followed by commit step");
  a_hold_on_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && status_i.out_busy |=> state_q == S_DONE)
    else $error("commit left while output blocked");
`endif

endmodule

### sv/wdt_dpath.sv
// Datapath: config registers, particle table, histogram, counters, output register.
module wdt_dpath import wdt_pkg::*; #(
  parameter int unsigned NUM_PARTICLES = NumParticlesDef,
  parameter int unsigned NUM_BINS      = NumBinsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  req_t                in_data_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output rsp_t                out_data_o
);

  localparam int unsigned PW       = $clog2(NUM_PARTICLES);
  localparam int unsigned BW       = $clog2(NUM_BINS);
  localparam int unsigned ClearLen = (NUM_PARTICLES > NUM_BINS) ? NUM_PARTICLES : NUM_BINS;
  localparam int unsigned CW       = $clog2(ClearLen);

  typedef struct packed {
    logic                 in_mid;
    logic                 crossed;
    logic [FrameW-1:0]    last_frame;
    logic signed [ZW-1:0] last_height;
    logic [FrameW-1:0]    entry_frame;
    logic signed [ZW-1:0] entry_height;
  } pentry_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // configuration
  logic [HeightW-1:0] height_q, cutoff_q;
  logic [MaxResW-1:0] max_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q  <= ChannelHeightRst;
      cutoff_q  <= WallCutoffRst;
      max_res_q <= MaxResidenceRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_HEIGHT: height_q  <= cfg_data_i[HeightW-1:0];
        CFG_WALL_CUTOFF:    cutoff_q  <= cfg_data_i[HeightW-1:0];
        CFG_MAX_RESIDENCE:  max_res_q <= cfg_data_i[MaxResW-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass counter
  logic [CW-1:0] clr_q;
  logic [31:0]   clr_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign clr_ext             = 32'(clr_q);
  assign status_o.clear_last = (clr_q == CW'(ClearLen - 1));

  // request register
  req_t        req_q;
  logic [31:0] in_pidx_ext, req_pidx_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= in_data_i;
  end

  assign in_pidx_ext  = 32'(in_data_i.particle_index);
  assign req_pidx_ext = 32'(req_q.particle_index);

  // particle table
  pentry_t          pmem [NUM_PARTICLES];
  pentry_t          pm_rdata_q;
  logic             pm_we;
  logic [PW-1:0]    pm_waddr;
  pentry_t          pm_wdata;

  always_ff @(posedge clk_i) begin
    if (pm_we) pmem[pm_waddr] <= pm_wdata;
    if (cmd_i.accept) pm_rdata_q <= pmem[in_pidx_ext[PW-1:0]];
  end

  // sample evaluation
  logic                 smp_ok, frame0, mid, ev_start, ev_end, top_cmp, binnable;
  logic signed [24:0]   z_ext, lo_b, hi_b;
  logic signed [25:0]   hsum, h_ext;
  logic [FrameW-1:0]    residence;
  logic [31:0]          res_ext, sel_ext;
  logic [BW-1:0]        bin_idx, hm_raddr;
  pentry_t              ent_nxt;

  always_comb begin
    smp_ok = (req_q.req_type == REQ_SAMPLE) && req_q.is_gas &&
             (req_pidx_ext < NUM_PARTICLES);
    frame0 = (req_q.frame == '0);
    z_ext  = $signed({req_q.height_z[ZW-1], req_q.height_z});
    lo_b   = $signed({2'b00, cutoff_q});
    hi_b   = $signed({2'b00, height_q}) - $signed({2'b00, cutoff_q});
    mid    = (z_ext >= lo_b) && (z_ext <= hi_b);

    ev_start = smp_ok && !frame0 && !mid && pm_rdata_q.in_mid;
    ev_end   = smp_ok && !frame0 && mid && pm_rdata_q.crossed;

    residence = req_q.frame - pm_rdata_q.entry_frame;
    hsum      = $signed({{2{pm_rdata_q.entry_height[ZW-1]}}, pm_rdata_q.entry_height}) +
                $signed({{2{req_q.height_z[ZW-1]}}, req_q.height_z});
    h_ext     = $signed({3'b000, height_q});
    top_cmp   = (hsum >= h_ext);
    binnable  = (residence < {{(FrameW-MaxResW){1'b0}}, max_res_q});

    res_ext = 32'(residence);
    bin_idx = (res_ext >= NUM_BINS) ? BW'(NUM_BINS - 1) : residence[BW-1:0];
    sel_ext = 32'(req_q.bin_select);
    hm_raddr = (req_q.req_type == REQ_READ) ? sel_ext[BW-1:0] : bin_idx;

    ent_nxt             = pm_rdata_q;
    ent_nxt.last_frame  = req_q.frame;
    ent_nxt.last_height = req_q.height_z;
    if (frame0) begin
      ent_nxt.in_mid = mid;
    end else if (!mid) begin
      if (pm_rdata_q.in_mid) begin
        ent_nxt.crossed      = 1'b1;
        ent_nxt.entry_frame  = pm_rdata_q.last_frame;
        ent_nxt.entry_height = pm_rdata_q.last_height;
      end
      ent_nxt.in_mid = 1'b0;
    end else begin
      ent_nxt.crossed = 1'b0;
      ent_nxt.in_mid  = 1'b1;
    end
  end

  always_comb begin
    pm_we    = (cmd_i.clear && (clr_ext < NUM_PARTICLES)) || (cmd_i.calc && smp_ok);
    pm_waddr = cmd_i.clear ? clr_q[PW-1:0] : req_pidx_ext[PW-1:0];
    pm_wdata = cmd_i.clear ? '0 : ent_nxt;
  end

  // second step registers
  logic [1:0]        s2_kind_q;
  logic [FrameW-1:0] s2_res_q;
  logic              s2_top_q, s2_bin_en_q, s2_rd_ok_q;
  logic [BW-1:0]     s2_bin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      s2_kind_q   <= ev_end ? EV_END : (ev_start ? EV_START : EV_NONE);
      s2_res_q    <= ev_end ? residence : '0;
      s2_top_q    <= ev_end && top_cmp;
      s2_bin_en_q <= ev_end && binnable;
      s2_bin_q    <= bin_idx;
      s2_rd_ok_q  <= (req_q.req_type == REQ_READ) && (sel_ext < NUM_BINS);
    end
  end

  // histogram
  logic [CountW-1:0] hmem [NUM_BINS];
  logic [CountW-1:0] hm_rdata_q, hm_wdata;
  logic              hm_we;
  logic [BW-1:0]     hm_waddr;

  always_comb begin
    hm_we    = (cmd_i.clear && (clr_ext < NUM_BINS)) || (cmd_i.done && s2_bin_en_q);
    hm_waddr = cmd_i.clear ? clr_q[BW-1:0] : s2_bin_q;
    hm_wdata = cmd_i.clear ? '0 : sat_inc(hm_rdata_q);
  end

  always_ff @(posedge clk_i) begin
    if (hm_we) hmem[hm_waddr] <= hm_wdata;
    if (cmd_i.calc) hm_rdata_q <= hmem[hm_raddr];
  end

  // running totals
  logic [FrameW-1:0] longest_q, longest_d;
  logic [CountW-1:0] start_cnt_q, start_cnt_d;
  logic [CountW-1:0] top_cnt_q, top_cnt_d;
  logic [CountW-1:0] bot_cnt_q, bot_cnt_d;
  logic              is_end;

  always_comb begin
    is_end      = (s2_kind_q == EV_END);
    longest_d   = (is_end && (s2_res_q > longest_q)) ? s2_res_q : longest_q;
    start_cnt_d = (s2_kind_q == EV_START) ? sat_inc(start_cnt_q) : start_cnt_q;
    top_cnt_d   = (is_end && s2_top_q) ? sat_inc(top_cnt_q) : top_cnt_q;
    bot_cnt_d   = (is_end && !s2_top_q) ? sat_inc(bot_cnt_q) : bot_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      longest_q   <= '0;
      start_cnt_q <= '0;
      top_cnt_q   <= '0;
      bot_cnt_q   <= '0;
    end else if (cmd_i.done) begin
      longest_q   <= longest_d;
      start_cnt_q <= start_cnt_d;
      top_cnt_q   <= top_cnt_d;
      bot_cnt_q   <= bot_cnt_d;
    end
  end

  // output register
  logic out_valid_q;
  rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      out_q.event_kind         <= s2_kind_q;
      out_q.residence_frames   <= s2_res_q;
      out_q.left_at_top        <= s2_top_q;
      out_q.was_binned         <= s2_bin_en_q;
      out_q.bin_count          <= s2_rd_ok_q ? hm_rdata_q : '0;
      out_q.longest_residence  <= longest_d;
      out_q.started_total      <= start_cnt_d;
      out_q.ended_top_total    <= top_cnt_d;
      out_q.ended_bottom_total <= bot_cnt_d;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

`ifndef SYNTHESIS
  a_no_commit_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |-> !(out_valid_q && out_stall_i))
    else $error("commit while output register is stalled");
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |=> out_valid_q)
    else $error("committed beat not presented");
  a_start_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> start_cnt_q >= $past(start_cnt_q))
    else $error("start counter went backwards");
`endif

endmodule

### dv/tb_wall_dwell_time_tracker_top.sv
`timescale 1ns / 100ps
// Testbench for the wall dwell-time tracker: directed and random particle tracks checked beat by beat.
module tb_wall_dwell_time_tracker_top;
  import wdt_pkg::*;

  localparam int unsigned NParticles     = NumParticlesDef;
  localparam int unsigned NBins          = NumBinsDef;
  localparam int unsigned PoolSize       = 12;
  localparam int unsigned ChunkLen       = 55;
  localparam int unsigned ChunksPerPhase = 4;
  localparam int unsigned NumPhases      = 6;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  req_t                in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rsp_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // tracker state as the testbench sees it
  logic [HeightW-1:0]   trk_height = ChannelHeightRst;
  logic [HeightW-1:0]   trk_cutoff = WallCutoffRst;
  logic [MaxResW-1:0]   trk_maxres = MaxResidenceRst;
  bit                   trk_in_mid [NParticles];
  bit                   trk_crossed [NParticles];
  logic [FrameW-1:0]    trk_last_frame [NParticles];
  logic [FrameW-1:0]    trk_entry_frame [NParticles];
  logic signed [ZW-1:0] trk_last_z [NParticles];
  logic signed [ZW-1:0] trk_entry_z [NParticles];
  logic [CountW-1:0]    trk_hist [NBins];
  logic [FrameW-1:0]    trk_longest = '0;
  logic [CountW-1:0]    trk_started = '0;
  logic [CountW-1:0]    trk_top = '0;
  logic [CountW-1:0]    trk_bottom = '0;

  req_t               sample_q [$];
  rsp_t               dwell_expect_q [$];
  bit [FrameW-1:0]    next_frame [NParticles];
  logic [11:0]        part_pool [PoolSize];
  bit                 quiet = 1'b0;
  int                 src_gap = 0;
  int                 sink_left = 0;
  bit                 sink_hold = 1'b0;
  int                 mismatches = 0;
  int                 beats_in = 0;
  int                 beats_out = 0;
  int                 n_reads = 0;
  int                 n_started = 0;
  int                 n_ended = 0;

  wall_dwell_time_tracker_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic void add_req(req_t rq);
    sample_q.insert(sample_q.size(), rq);
  endfunction

  function automatic rsp_t predict_dwell(req_t rq);
    rsp_t        rs;
    logic [11:0] p;
    logic [FrameW-1:0] res;
    logic [7:0]  bin;
    longint      z, lo, hi;
    bit          mid;
    rs = '0;
    if (rq.req_type == REQ_READ) begin
      rs.bin_count = trk_hist[rq.bin_select];
      n_reads++;
    end else if (rq.is_gas) begin
      p   = rq.particle_index;
      z   = $signed(rq.height_z);
      lo  = longint'(trk_cutoff);
      hi  = longint'(trk_height) - longint'(trk_cutoff);
      mid = (z >= lo) && (z <= hi);
      if (rq.frame == '0) begin
        trk_in_mid[p] = mid;
      end else if (!mid) begin
        if (trk_in_mid[p]) begin
          trk_crossed[p]     = 1'b1;
          trk_entry_frame[p] = trk_last_frame[p];
          trk_entry_z[p]     = trk_last_z[p];
          trk_started        = sat_inc(trk_started);
          rs.event_kind      = EV_START;
          n_started++;
        end
        trk_in_mid[p] = 1'b0;
      end else begin
        if (trk_crossed[p]) begin
          res = rq.frame - trk_entry_frame[p];
          rs.residence_frames = res;
          rs.left_at_top = longint'(trk_entry_z[p]) + z >= longint'(trk_height);
          if (res < {15'b0, trk_maxres}) begin
            bin = (res > 24'd255) ? 8'd255 : res[7:0];
            trk_hist[bin] = sat_inc(trk_hist[bin]);
            rs.was_binned = 1'b1;
          end
          if (res > trk_longest) trk_longest = res;
          if (rs.left_at_top) trk_top = sat_inc(trk_top);
          else trk_bottom = sat_inc(trk_bottom);
          trk_crossed[p] = 1'b0;
          rs.event_kind  = EV_END;
          n_ended++;
        end
        trk_in_mid[p] = 1'b1;
      end
      trk_last_frame[p] = rq.frame;
      trk_last_z[p]     = rq.height_z;
    end
    rs.longest_residence  = trk_longest;
    rs.started_total      = trk_started;
    rs.ended_top_total    = trk_top;
    rs.ended_bottom_total = trk_bottom;
    return rs;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic req_t gas_sample(int p, int f, int z);
    req_t rq;
    rq = '0;
    rq.req_type       = REQ_SAMPLE;
    rq.is_gas         = 1'b1;
    rq.particle_index = 12'(p);
    rq.frame          = FrameW'(f);
    rq.height_z       = ZW'(z);
    return rq;
  endfunction

  function automatic req_t bin_read(int b);
    req_t rq;
    rq = '0;
    rq.req_type   = REQ_READ;
    rq.bin_select = 8'(b);
    return rq;
  endfunction

  // mostly coherent per-particle tracks; some reads, ignored samples and raw noise
  function automatic req_t random_item();
    req_t        rq;
    logic [95:0] raw;
    logic [11:0] p;
    longint      z, lo, hi, span;
    int          r;
    raw = {$urandom(), $urandom(), $urandom()};
    rq  = raw[$bits(req_t)-1:0];
    r   = $urandom_range(0, 99);
    if (r < 8) begin
      rq.req_type = REQ_READ;
      if ($urandom_range(0, 1)) rq.bin_select = 8'($urandom_range(0, 15));
    end else if (r < 13) begin
      rq.req_type = REQ_SAMPLE;
      rq.is_gas   = 1'b0;
    end else begin
      rq.req_type = REQ_SAMPLE;
      rq.is_gas   = 1'b1;
      p = part_pool[$urandom_range(0, PoolSize-1)];
      rq.particle_index = p;
      r = $urandom_range(0, 99);
      if (r < 4) next_frame[p] = '0;
      else if (r < 8) next_frame[p] = rq.frame;  // jump anywhere, backwards too
      else if (r < 85) next_frame[p] += FrameW'($urandom_range(r < 12 ? 0 : 1, 3));
      else if (r < 97) next_frame[p] += FrameW'($urandom_range(4, 60));
      else next_frame[p] += FrameW'($urandom_range(100, 400));
      rq.frame = next_frame[p];

      lo   = longint'(trk_cutoff);
      hi   = longint'(trk_height) - longint'(trk_cutoff);
      span = $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 8388607);
      r    = $urandom_range(0, 99);
      if (r < 50 && hi >= lo) begin
        if (r < 8) z = lo;
        else if (r < 16) z = hi;
        else z = lo + longint'($urandom_range(0, 32'(hi - lo)));
      end else if (r < 73) begin
        z = lo - 1 - span;
      end else if (r < 96) begin
        z = hi + 1 + span;
      end else begin
        z = $signed(rq.height_z);
      end
      if (z < -8388608) z = -8388608;
      if (z > 8388607) z = 8388607;
      rq.height_z = z[ZW-1:0];
    end
    return rq;
  endfunction

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      note_error($sformatf("result beat %0d, %s: expected 0x%0h, got 0x%0h",
                           beats_out, name, want, got));
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CHANNEL_HEIGHT: trk_height = val;
      CFG_WALL_CUTOFF:    trk_cutoff = val;
      CFG_MAX_RESIDENCE:  trk_maxres = val[MaxResW-1:0];
      default: ;
    endcase
  endtask

  // wait for every expected result, then let the pipeline go quiet
  task automatic settle();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_valid || dwell_expect_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_beats
    bit   took;
    rsp_t exp_rs;
    took = in_valid && !in_stall;
    if (took) begin
      exp_rs = predict_dwell(in_data);
      dwell_expect_q.insert(dwell_expect_q.size(), exp_rs);
      beats_in++;
      src_gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    end
    // a stalled beat is held as is
    if (rst_n && (took || !in_valid)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (dwell_expect_q.size() == 0) begin
        note_error($sformatf("result beat %0d: nothing expected, got event_kind %0d",
                             beats_out, out_data.event_kind));
      end else begin
        want = dwell_expect_q.pop_front();
        cmp_field("event_kind", want.event_kind, out_data.event_kind);
        cmp_field("residence_frames", want.residence_frames, out_data.residence_frames);
        cmp_field("left_at_top", want.left_at_top, out_data.left_at_top);
        cmp_field("was_binned", want.was_binned, out_data.was_binned);
        cmp_field("bin_count", want.bin_count, out_data.bin_count);
        cmp_field("longest_residence", want.longest_residence, out_data.longest_residence);
        cmp_field("started_total", want.started_total, out_data.started_total);
        cmp_field("ended_top_total", want.ended_top_total, out_data.ended_top_total);
        cmp_field("ended_bottom_total", want.ended_bottom_total, out_data.ended_bottom_total);
      end
      beats_out++;
    end
    if (!quiet && sink_left == 0) begin
      sink_hold = ($urandom_range(0, 99) < 35);
      sink_left = sink_hold ? pick_gap() : $urandom_range(1, 20);
    end
    if (sink_left > 0) sink_left--;
    out_stall <= !quiet && sink_hold;
  end

  initial begin : stimulus
    int ph;
    int ck;
    int h;
    foreach (trk_hist[i]) trk_hist[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: begin
            write_reg(CFG_CHANNEL_HEIGHT, 23'h7FFFFF);
            write_reg(CFG_WALL_CUTOFF, 23'd0);
            write_reg(CFG_MAX_RESIDENCE, 23'd256);
          end
          2: begin
            // middle shrinks to the single height zero
            write_reg(CFG_CHANNEL_HEIGHT, 23'd0);
            write_reg(CFG_WALL_CUTOFF, 23'd0);
            write_reg(CFG_MAX_RESIDENCE, 23'd1);
          end
          3: begin
            // inverted bounds: nothing is in the middle
            write_reg(CFG_CHANNEL_HEIGHT, 23'd1000);
            write_reg(CFG_WALL_CUTOFF, 23'h7FFFFF);
            write_reg(CFG_MAX_RESIDENCE, 23'd100);
          end
          4: begin
            h = $urandom_range(2000, 60000);
            write_reg(CFG_CHANNEL_HEIGHT, CfgDataW'(h));
            write_reg(CFG_WALL_CUTOFF, CfgDataW'($urandom_range(0, h / 2 + 500)));
            write_reg(CFG_MAX_RESIDENCE, CfgDataW'($urandom_range(1, 256)));
          end
          default: begin
            write_reg(CFG_CHANNEL_HEIGHT, ChannelHeightRst);
            write_reg(CFG_WALL_CUTOFF, WallCutoffRst);
            write_reg(CFG_MAX_RESIDENCE, CfgDataW'(MaxResidenceRst));
          end
        endcase
      end

      part_pool[0] = '0;
      part_pool[1] = 12'hFFF;
      for (int i = 2; i < PoolSize; i++) part_pool[i] = 12'($urandom_range(0, NParticles-1));

      if (ph == 0) begin
        add_req(bin_read(0));
        // bottom exit; an ignored sample mid-collision
        add_req(gas_sample(0, 0, 12800));
        add_req(gas_sample(0, 1, 5000));
        add_req(gas_sample(0, 2, 0));
        add_req(gas_sample(0, 3, -8388608));
        add_req(gas_sample(0, 4, 12800));
        sample_q[$].is_gas = 1'b0;
        add_req(gas_sample(0, 7, 3840));
        // both middle bounds exactly, top exit on equality
        add_req(gas_sample(4095, 0, 21760));
        add_req(gas_sample(4095, 5, 21761));
        add_req(gas_sample(4095, 9, 8388607));
        add_req(gas_sample(4095, 10, 3840));
        // frame zero while a collision is open
        add_req(gas_sample(1, 0, 10000));
        add_req(gas_sample(1, 1, 3839));
        add_req(gas_sample(1, 0, 10000));
        add_req(gas_sample(1, 3, 10000));
        // zero residence within one frame
        add_req(gas_sample(2, 0, 0));
        add_req(gas_sample(2, 4, 5000));
        add_req(gas_sample(2, 4, -1));
        add_req(gas_sample(2, 4, 20000));
        // residence at max_residence and one below
        add_req(gas_sample(3, 0, 12800));
        add_req(gas_sample(3, 1, 4000000));
        add_req(gas_sample(3, 200, 12800));
        add_req(gas_sample(3, 201, -20));
        add_req(gas_sample(3, 399, 12800));
        add_req(bin_read(199));
      end

      for (ck = 0; ck < ChunksPerPhase; ck++) begin
        quiet = (ck == 1);
        repeat (ChunkLen) add_req(random_item());
        do @(posedge clk); while (sample_q.size() != 0);
        if (ck == 2) settle();
      end
      quiet = 1'b0;

      if (ph == NumPhases - 1) begin
        // frames going backwards: residence wraps around 2^24
        add_req(gas_sample(7, 0, 12800));
        add_req(gas_sample(7, 100, 12800));
        add_req(gas_sample(7, 101, 25000));
        add_req(gas_sample(7, 50, 12800));
      end
    end

    settle();
    $display("%0d request beats (%0d bin reads) over %0d register settings: %0d starts, %0d ends",
             beats_in, n_reads, NumPhases, n_started, n_ended);
    $display("%0d result beats checked, %0d mismatches, %0d results outstanding",
             beats_out, mismatches, dwell_expect_q.size());
    if (mismatches == 0 && dwell_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
sv/wdt_pkg.sv
sv/wdt_ctrl.sv
sv/wdt_dpath.sv
sv/wall_dwell_time_tracker_top.sv
dv/tb_wall_dwell_time_tracker_top.sv
